// ----- rtl/core/kstat_pkg.sv -----
package kstat_pkg;

    localparam int ENTRIES     = 4096;
    localparam int COUNT_LIMIT = 16384;
    localparam int SLOTS       = 2 * ENTRIES;
    localparam int ENT_W       = $clog2(ENTRIES);
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int USED_W      = ENT_W + 1;
    localparam int CNT_W       = 15;
    localparam int SUM_W       = 16;
    localparam int KEY_W       = 64;
    localparam int MOVE_W      = 16;
    localparam int PCT_W       = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 144;
    localparam int PROD_W      = 23;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAMES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PCT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM   = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [ENT_W-1:0]  pos;
    } t_slot;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [MOVE_W-1:0] move;
        logic              side;
        logic [CNT_W-1:0]  cnt;
        logic [SUM_W-1:0]  sum;
    } t_entry;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic slot_rd;
        logic ent_rd_slot;
        logic ent_rd_idx;
        logic idx_inc;
        logic idx_start;
        logic create;
        logic update;
        logic halve;
        logic load_rd;
        logic set_full;
        logic set_unused;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic in_req;
        logic clr_last;
        logic slot_valid;
        logic match;
        logic at_limit;
        logic table_full;
        logic rd_unused;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/core/kstat_ctrl.sv -----
module kstat_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  kstat_pkg::t_stat i_stat,
    output kstat_pkg::t_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_CLR   = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_RSEL  = 12'b000000000100,
        S_RLD   = 12'b000000001000,
        S_SRD   = 12'b000000010000,
        S_SCHK  = 12'b000000100000,
        S_ECHK  = 12'b000001000000,
        S_HSRD  = 12'b000010000000,
        S_HSCHK = 12'b000100000000,
        S_HECHK = 12'b001000000000,
        S_FIN   = 12'b010000000000,
        S_SPARE = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_stat.in_req ? S_RSEL : S_SRD;
                end
            end
            S_RSEL: begin
                if (i_stat.rd_unused) begin
                    o_cmd.set_unused = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.ent_rd_idx = 1'b1;
                    n_state = S_RLD;
                end
            end
            S_RLD: begin
                o_cmd.load_rd = 1'b1;
                n_state = S_FIN;
            end
            S_SRD: begin
                o_cmd.slot_rd = 1'b1;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (i_stat.slot_valid) begin
                    o_cmd.ent_rd_slot = 1'b1;
                    n_state = S_ECHK;
                end else if (i_stat.table_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.create = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_ECHK: begin
                if (i_stat.match) begin
                    o_cmd.update = 1'b1;
                    if (i_stat.at_limit) begin
                        o_cmd.idx_start = 1'b1;
                        n_state = S_HSRD;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_HSRD: begin
                o_cmd.slot_rd = 1'b1;
                n_state = S_HSCHK;
            end
            S_HSCHK: begin
                if (i_stat.slot_valid) begin
                    o_cmd.ent_rd_slot = 1'b1;
                    n_state = S_HECHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_HECHK: begin
                o_cmd.halve   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_HSRD;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/kstat_dp.sv -----
module kstat_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kstat_pkg::t_cmd                      i_cmd,
    output kstat_pkg::t_stat                     o_stat,
    input  logic                                 i_cfg_we,
    input  logic [kstat_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kstat_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_req,
    input  logic [kstat_pkg::IN_DATA_W-1:0]      i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_out_status,
    output logic [kstat_pkg::OUT_DATA_W-1:0]     o_out_data
);

    kstat_pkg::t_slot  slot_mem [kstat_pkg::SLOTS];
    kstat_pkg::t_entry ent_mem  [kstat_pkg::ENTRIES];

    logic [kstat_pkg::KEY_W-1:0]  r_key;
    logic [kstat_pkg::MOVE_W-1:0] r_move;
    logic                         r_side;
    logic [1:0]                   r_res;
    logic [kstat_pkg::ENT_W-1:0]  r_ridx;
    logic [kstat_pkg::SLOT_W-1:0] r_idx;
    logic [kstat_pkg::SLOT_W-1:0] r_clr;
    logic [kstat_pkg::USED_W-1:0] r_used;
    kstat_pkg::t_slot             r_slot_q;
    kstat_pkg::t_entry            r_ent_q;
    logic [kstat_pkg::ENT_W-1:0]  r_pos;
    logic [kstat_pkg::ENT_W-1:0]  r_p;
    kstat_pkg::t_entry            r_cur;
    logic [1:0]                   r_status;
    logic                         r_zero;

    logic [kstat_pkg::CNT_W-1:0]  r_min_games;
    logic [kstat_pkg::PCT_W-1:0]  r_min_pct;
    logic                         r_drop_w;
    logic                         r_drop_b;
    logic                         r_uniform;

    logic                         r_out_valid;
    logic [1:0]                   r_out_status;
    logic [kstat_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [1:0]                   add;
    logic [kstat_pkg::CNT_W-1:0]  cnt_inc;
    logic [kstat_pkg::SUM_W-1:0]  sum_inc;
    logic [kstat_pkg::CNT_W-1:0]  cnt_half;
    logic [kstat_pkg::SUM_W-1:0]  sum_half;
    logic                         key_eq;
    kstat_pkg::t_entry            upd_ent;
    kstat_pkg::t_entry            half_ent;
    kstat_pkg::t_entry            new_ent;
    logic                         ent_we;
    logic [kstat_pkg::ENT_W-1:0]  ent_wa;
    kstat_pkg::t_entry            ent_wd;
    logic                         slot_we;
    logic [kstat_pkg::SLOT_W-1:0] slot_wa;
    kstat_pkg::t_slot             slot_wd;
    logic [kstat_pkg::PROD_W-1:0] score_l;
    logic [kstat_pkg::PROD_W-1:0] score_r;
    logic [kstat_pkg::SUM_W-1:0]  weight;
    logic                         keep;

    always_comb begin
        add = (r_res == 2'b01) ? 2'd2 : (r_res == 2'b00) ? 2'd1 : 2'd0;
        key_eq = (r_ent_q.key == r_key);
        cnt_inc = r_ent_q.cnt + kstat_pkg::CNT_W'(1);
        sum_inc = r_ent_q.sum + kstat_pkg::SUM_W'(add);
        cnt_half = kstat_pkg::CNT_W'(({1'b0, r_ent_q.cnt} + 16'd1) >> 1);
        sum_half = kstat_pkg::SUM_W'(({1'b0, r_ent_q.sum} + 17'd1) >> 1);
        upd_ent = r_ent_q;
        upd_ent.cnt = cnt_inc;
        upd_ent.sum = sum_inc;
        half_ent = r_ent_q;
        half_ent.cnt = cnt_half;
        half_ent.sum = sum_half;
        new_ent.key  = r_key;
        new_ent.move = r_move;
        new_ent.side = r_side;
        new_ent.cnt  = kstat_pkg::CNT_W'(1);
        new_ent.sum  = kstat_pkg::SUM_W'(add);

        ent_we = 1'b0;
        ent_wa = r_pos;
        ent_wd = upd_ent;
        if (i_cmd.create) begin
            ent_we = 1'b1;
            ent_wa = r_used[kstat_pkg::ENT_W-1:0];
            ent_wd = new_ent;
        end else if (i_cmd.update) begin
            ent_we = 1'b1;
        end else if (i_cmd.halve && key_eq) begin
            ent_we = 1'b1;
            ent_wd = half_ent;
        end

        slot_we = i_cmd.clr_step || i_cmd.create;
        slot_wa = i_cmd.clr_step ? r_clr : r_idx;
        slot_wd.valid = i_cmd.create;
        slot_wd.pos   = r_used[kstat_pkg::ENT_W-1:0];

        o_stat.in_req     = i_in_req;
        o_stat.clr_last   = (r_clr == kstat_pkg::SLOT_W'(kstat_pkg::SLOTS - 1));
        o_stat.slot_valid = r_slot_q.valid;
        o_stat.match      = key_eq && (r_ent_q.move == r_move);
        o_stat.at_limit   = ({1'b0, cnt_inc} >= 16'(kstat_pkg::COUNT_LIMIT));
        o_stat.table_full = (r_used >= kstat_pkg::USED_W'(kstat_pkg::ENTRIES));
        o_stat.rd_unused  = ({1'b0, r_ridx} >= r_used);
        o_stat.out_free   = !r_out_valid || i_out_ready;

        weight  = r_uniform ? kstat_pkg::SUM_W'(1) : r_cur.sum;
        score_l = kstat_pkg::PROD_W'(r_cur.sum) * kstat_pkg::PROD_W'(50);
        score_r = kstat_pkg::PROD_W'(r_min_pct) * kstat_pkg::PROD_W'(r_cur.cnt);
        keep = (r_cur.cnt >= r_min_games) && (r_cur.sum != '0) && (score_l >= score_r)
            && !(r_drop_w && !r_cur.side) && !(r_drop_b && r_cur.side) && (weight != '0);
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) slot_mem[slot_wa] <= slot_wd;
        if (i_cmd.slot_rd) r_slot_q <= slot_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) ent_mem[ent_wa] <= ent_wd;
        if (i_cmd.ent_rd_slot) begin
            r_ent_q <= ent_mem[r_slot_q.pos];
        end else if (i_cmd.ent_rd_idx) begin
            r_ent_q <= ent_mem[r_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_in_data[63:0];
            r_move <= i_in_data[79:64];
            r_side <= i_in_data[80];
            r_res  <= i_in_data[82:81];
            r_ridx <= i_in_data[94:83];
            r_idx  <= i_in_data[kstat_pkg::SLOT_W-1:0];
            r_zero <= 1'b0;
        end
        if (i_cmd.idx_start) r_idx <= r_key[kstat_pkg::SLOT_W-1:0];
        if (i_cmd.idx_inc) r_idx <= r_idx + kstat_pkg::SLOT_W'(1);
        if (i_cmd.ent_rd_slot) r_pos <= r_slot_q.pos;
        if (i_cmd.create) begin
            r_p      <= r_used[kstat_pkg::ENT_W-1:0];
            r_cur    <= new_ent;
            r_status <= kstat_pkg::ST_CREATED;
        end
        if (i_cmd.update) begin
            r_p      <= r_pos;
            r_cur    <= upd_ent;
            r_status <= kstat_pkg::ST_UPDATED;
        end
        if (i_cmd.halve && key_eq && (r_pos == r_p)) r_cur <= half_ent;
        if (i_cmd.load_rd) begin
            r_p      <= r_ridx;
            r_cur    <= r_ent_q;
            r_status <= kstat_pkg::ST_UPDATED;
        end
        if (i_cmd.set_full) begin
            r_p      <= '0;
            r_zero   <= 1'b1;
            r_status <= kstat_pkg::ST_FULL;
        end
        if (i_cmd.set_unused) begin
            r_p      <= r_ridx;
            r_zero   <= 1'b1;
            r_status <= kstat_pkg::ST_UNUSED;
        end
        if (i_cmd.fin) begin
            r_out_status <= r_status;
            if (r_zero) begin
                r_out_data <= kstat_pkg::OUT_DATA_W'(r_p);
            end else begin
                r_out_data <= {3'b000, weight, keep, r_cur.sum, r_cur.cnt, r_cur.side,
                               r_cur.move, r_cur.key, r_p};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_min_games <= kstat_pkg::CNT_W'(3);
            r_min_pct   <= '0;
            r_drop_w    <= 1'b0;
            r_drop_b    <= 1'b0;
            r_uniform   <= 1'b0;
        end else begin
            if (i_cmd.create) r_used <= r_used + kstat_pkg::USED_W'(1);
            if (i_cmd.clr_step) r_clr <= r_clr + kstat_pkg::SLOT_W'(1);
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kstat_pkg::CFG_MIN_GAMES: r_min_games <= i_cfg_data;
                    kstat_pkg::CFG_MIN_PCT:   r_min_pct   <= i_cfg_data[kstat_pkg::PCT_W-1:0];
                    kstat_pkg::CFG_DROP_W:    r_drop_w    <= i_cfg_data[0];
                    kstat_pkg::CFG_DROP_B:    r_drop_b    <= i_cfg_data[0];
                    kstat_pkg::CFG_UNIFORM:   r_uniform   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;

endmodule

// ----- rtl/core/keyed_stat_hash_accumulator.sv -----
// an accumulate reads the home slot, then its entry; on a miss it steps on to the next slot
// an empty slot creates the entry or answers full; a read request loads the indexed entry
// at the count limit a halving walk goes over the key's slot run up to the empty slot
// the next request is taken once the result is loaded; a result not yet taken stalls it
// synchronous active-low reset clears the fill count and output valid, sets config defaults
// after reset a clearing pass empties all 8192 slots of the slot memory, tready low meanwhile
module keyed_stat_hash_accumulator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pos_key, move_code, side_to_move, game_result, read_index, zero pad
    input  logic [kstat_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // entry_pos, entry_key, entry_move, entry_side, game_count, result_sum, keep, weight, pad
    output logic [kstat_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status
    output logic [1:0]                           m_axis_tuser,
    input  logic                                 i_cfg_we,
    input  logic [kstat_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kstat_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    kstat_pkg::t_cmd  cmd;
    kstat_pkg::t_stat stat;

    kstat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    kstat_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_req     (s_axis_tuser),
        .i_in_data    (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (m_axis_tuser),
        .o_out_data   (m_axis_tdata)
    );

endmodule

// ----- bench/tb.sv -----
module tb;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SLOT_MASK   = kstat_pkg::SLOTS - 1;

    typedef struct {
        bit        rd;
        bit [63:0] key;
        bit [15:0] move;
        bit        side;
        bit [1:0]  res;
        bit [11:0] ridx;
    } t_req;

    typedef struct {
        bit [1:0]  status;
        bit [11:0] pos;
        bit [63:0] key;
        bit [15:0] move;
        bit        side;
        bit [14:0] games;
        bit [15:0] sum;
        bit        keep;
        bit [15:0] weight;
    } t_stat_rec;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [kstat_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [kstat_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]                       m_axis_tuser;
    logic                             i_cfg_we = 1'b0;
    logic [kstat_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [kstat_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    keyed_stat_hash_accumulator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // table mirror
    bit        slot_used [kstat_pkg::SLOTS];
    bit [11:0] slot_pos  [kstat_pkg::SLOTS];
    bit [63:0] ent_key   [kstat_pkg::ENTRIES];
    bit [15:0] ent_move  [kstat_pkg::ENTRIES];
    bit        ent_side  [kstat_pkg::ENTRIES];
    int        ent_games [kstat_pkg::ENTRIES];
    int        ent_sum   [kstat_pkg::ENTRIES];
    int        used_cnt = 0;

    int min_games = 3;
    int min_pct = 0;
    bit drop_white = 0;
    bit drop_black = 0;
    bit uniform = 0;

    t_req      pending_reqs[$];
    t_stat_rec expected_stats[$];
    t_req      cur_req;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        errors = 0;
    int        cycles = 0;
    bit [63:0] key_pool [48];

    function automatic int entry_weight(int p);
        return uniform ? 1 : ent_sum[p];
    endfunction

    function automatic bit entry_kept(int p);
        longint n, s;
        n = ent_games[p];
        s = ent_sum[p];
        if (n < min_games) return 0;
        if (s == 0) return 0;
        if (s * 50 < longint'(min_pct) * n) return 0;
        if (drop_white && ent_side[p] == 1'b0) return 0;
        if (drop_black && ent_side[p] == 1'b1) return 0;
        if (entry_weight(p) == 0) return 0;
        return 1;
    endfunction

    function automatic t_stat_rec entry_stat(bit [1:0] st, int p);
        t_stat_rec r;
        r.status = st;
        r.pos    = p[11:0];
        r.key    = ent_key[p];
        r.move   = ent_move[p];
        r.side   = ent_side[p];
        r.games  = ent_games[p][14:0];
        r.sum    = ent_sum[p][15:0];
        r.keep   = entry_kept(p);
        r.weight = 16'(entry_weight(p));
        return r;
    endfunction

    function automatic void halve_key_run(bit [63:0] key);
        int idx, p;
        idx = int'(key[kstat_pkg::SLOT_W-1:0]);
        for (int n = 0; n < kstat_pkg::SLOTS && slot_used[idx]; n++) begin
            p = slot_pos[idx];
            if (ent_key[p] == key) begin
                ent_games[p] = (ent_games[p] + 1) / 2;
                ent_sum[p]   = (ent_sum[p] + 1) / 2;
            end
            idx = (idx + 1) & SLOT_MASK;
        end
    endfunction

    function automatic t_stat_rec apply_request(t_req q);
        t_stat_rec r;
        int idx, p, gain;
        bit hit;
        r = '{default: '0};
        if (q.rd) begin
            if (q.ridx >= used_cnt) begin
                r.status = kstat_pkg::ST_UNUSED;
                r.pos = q.ridx;
                return r;
            end
            return entry_stat(kstat_pkg::ST_UPDATED, q.ridx);
        end
        gain = (q.res == 2'd1) ? 2 : (q.res == 2'd0) ? 1 : 0;
        idx = int'(q.key[kstat_pkg::SLOT_W-1:0]);
        hit = 0;
        p = 0;
        for (int n = 0; n < kstat_pkg::SLOTS && slot_used[idx]; n++) begin
            if (ent_key[slot_pos[idx]] == q.key && ent_move[slot_pos[idx]] == q.move) begin
                hit = 1;
                p = slot_pos[idx];
                break;
            end
            idx = (idx + 1) & SLOT_MASK;
        end
        if (!hit) begin
            if (used_cnt >= kstat_pkg::ENTRIES || slot_used[idx]) begin
                r.status = kstat_pkg::ST_FULL;
                return r;
            end
            p = used_cnt++;
            ent_key[p] = q.key;
            ent_move[p] = q.move;
            ent_side[p] = q.side;
            ent_games[p] = 0;
            ent_sum[p] = 0;
            slot_used[idx] = 1;
            slot_pos[idx] = p[11:0];
        end
        ent_games[p] += 1;
        ent_sum[p] += gain;
        if (ent_games[p] >= kstat_pkg::COUNT_LIMIT) halve_key_run(q.key);
        return entry_stat(hit ? kstat_pkg::ST_UPDATED : kstat_pkg::ST_CREATED, p);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) expected_stats.push_back(apply_request(cur_req));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {1'b0, cur_req.ridx, cur_req.res, cur_req.side,
                                     cur_req.move, cur_req.key};
                    s_axis_tuser <= cur_req.rd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_stat_rec want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t unexpected result status %0d", $time, m_axis_tuser);
                    errors++;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("status", want.status, m_axis_tuser);
                    check_field("entry_pos", want.pos, m_axis_tdata[11:0]);
                    check_field("entry_key", want.key, m_axis_tdata[75:12]);
                    check_field("entry_move", want.move, m_axis_tdata[91:76]);
                    check_field("entry_side", want.side, m_axis_tdata[92]);
                    check_field("game_count", want.games, m_axis_tdata[107:93]);
                    check_field("result_sum", want.sum, m_axis_tdata[123:108]);
                    check_field("keep", want.keep, m_axis_tdata[124]);
                    check_field("weight", want.weight, m_axis_tdata[140:125]);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_cfg(logic [kstat_pkg::CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[kstat_pkg::CFG_DATA_W-1:0];
        case (idx)
            kstat_pkg::CFG_MIN_GAMES: min_games = val & 16'h7fff;
            kstat_pkg::CFG_MIN_PCT:   min_pct = val & 8'h7f;
            kstat_pkg::CFG_DROP_W:    drop_white = val[0];
            kstat_pkg::CFG_DROP_B:    drop_black = val[0];
            kstat_pkg::CFG_UNIFORM:   uniform = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(int games, int pct, bit dw, bit db, bit uni);
        write_cfg(kstat_pkg::CFG_MIN_GAMES, games);
        write_cfg(kstat_pkg::CFG_MIN_PCT, pct);
        write_cfg(kstat_pkg::CFG_DROP_W, dw);
        write_cfg(kstat_pkg::CFG_DROP_B, db);
        write_cfg(kstat_pkg::CFG_UNIFORM, uni);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_stats.size() > 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_req acc(bit [63:0] key, bit [15:0] move, bit side, bit [1:0] res);
        t_req q;
        q.rd = 0;
        q.key = key;
        q.move = move;
        q.side = side;
        q.res = res;
        q.ridx = 12'($urandom);
        return q;
    endfunction

    function automatic t_req rd_req(bit [11:0] idx);
        t_req q;
        q = acc({$urandom, $urandom}, 16'($urandom), 1'($urandom), 2'($urandom));
        q.rd = 1;
        q.ridx = idx;
        return q;
    endfunction

    function automatic t_req random_req();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20)
            return rd_req($urandom_range(1) ? 12'($urandom) : 12'($urandom_range(80)));
        if (sel < 30)
            return acc({$urandom, $urandom}, 16'($urandom), 1'($urandom), 2'($urandom));
        return acc(key_pool[$urandom_range(47)], 16'($urandom_range(5)),
                   1'($urandom), 2'($urandom));
    endfunction

    task automatic random_phase(int n, int send_idle, int recv_stall);
        send_idle_pct = send_idle;
        recv_stall_pct = recv_stall;
        repeat (n) pending_reqs.push_back(random_req());
        drain();
    endtask

    initial begin
        for (int i = 0; i < 48; i++) begin
            key_pool[i] = {$urandom, $urandom};
            // some keys share their home slot
            if (i % 4 == 1) key_pool[i][12:0] = key_pool[i-1][12:0];
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_config(3, 0, 0, 0, 0);

        // directed
        pending_reqs.push_back(rd_req(12'd0));
        pending_reqs.push_back(acc(64'd0, 16'd0, 1'b0, 2'd1));
        pending_reqs.push_back(acc(64'd0, 16'd0, 1'b1, 2'd0));
        pending_reqs.push_back(acc(64'd0, 16'd0, 1'b0, 2'd3));
        pending_reqs.push_back(acc(64'd0, 16'd0, 1'b0, 2'd2));
        pending_reqs.push_back(acc('1, 16'hffff, 1'b1, 2'd1));
        pending_reqs.push_back(acc('1, 16'hffff, 1'b1, 2'd1));
        pending_reqs.push_back(acc('1, 16'hffff, 1'b0, 2'd1));
        pending_reqs.push_back(acc(64'h8000_0000_0000_0000, 16'h0001, 1'b1, 2'd2));
        pending_reqs.push_back(acc(64'h0000_0000_0000_2000, 16'h8000, 1'b0, 2'd3));
        pending_reqs.push_back(acc(64'h0000_0000_0000_0000, 16'h0002, 1'b1, 2'd0));
        pending_reqs.push_back(acc(64'h0000_0000_0000_1fff, 16'h0000, 1'b0, 2'd1));
        pending_reqs.push_back(acc(64'hffff_ffff_ffff_dfff, 16'h0000, 1'b1, 2'd0));
        pending_reqs.push_back(rd_req(12'd0));
        pending_reqs.push_back(rd_req(12'd1));
        pending_reqs.push_back(rd_req(12'd5));
        pending_reqs.push_back(rd_req(12'd8));
        pending_reqs.push_back(rd_req(12'd9));
        pending_reqs.push_back(rd_req(12'hfff));
        pending_reqs.push_back(rd_req(12'h800));
        drain();

        set_config(1, 0, 0, 0, 0);
        random_phase(400, 0, 0);
        set_config(16384, 100, 1, 0, 0);
        random_phase(400, 69, 0);
        set_config(0, 127, 0, 1, 1);
        random_phase(400, 0, 69);
        set_config(2, 50, 0, 0, 0);
        random_phase(400, 32, 32);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/kstat_pkg.sv
rtl/core/kstat_ctrl.sv
rtl/core/kstat_dp.sv
rtl/core/keyed_stat_hash_accumulator.sv
bench/tb.sv
